@@ hw/rtl/htlp_pkg.sv @@
// Shared types and codes for the linear-probe hash table core.
`timescale 1ns / 1ps

package htlp_pkg;

    // Golden-ratio fraction (sqrt(5)-1)/2 held to 64 bits; truncate from the top.
    localparam logic [63:0] GOLDEN_FRAC64 = 64'h9E37_79B9_7F4A_7C15;

    // Operation codes on i_action.
    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // Slot state codes.
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef enum logic [1:0] {
        RES_PUT_OK,
        RES_FOUND,
        RES_FULL,
        RES_NOT_FOUND
    } t_result_sel;

    typedef struct packed {
        logic        load;
        logic        hash_mul;
        logic        hash_fold;
        logic        home;
        logic        issue;
        logic        advance;
        logic        clear;
        logic        write_live;
        logic        write_tomb;
        logic        used_inc;
        logic        used_dec;
        logic        result_en;
        t_result_sel result_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       len_zero;
        logic       cnt_last;
        logic       full;
        logic       clear_last;
        logic       slot_empty;
        logic       slot_live;
        logic       key_match;
        logic       last_probe;
    } t_dp_stat;

endpackage

@@ hw/rtl/htlp_datapath.sv @@
// Datapath: key latch, hash unit, slot memories, probe pointers and result registers.
`timescale 1ns / 1ps

module htlp_datapath #(
    parameter int TABLE_SLOTS        = 64,
    parameter int KEY_CHARS          = 8,
    parameter int HASH_FRACTION_BITS = 32,
    parameter int SLOT_W             = $clog2(TABLE_SLOTS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  htlp_pkg::t_dp_cmd      i_cmd,
    output htlp_pkg::t_dp_stat     o_stat,
    input  logic [1:0]             i_action,
    input  logic [63:0]            i_key_bytes,
    input  logic [3:0]             i_key_length,
    input  logic signed [31:0]     i_new_value,
    output logic [1:0]             o_status,
    output logic signed [31:0]     o_found_value,
    output logic [SLOT_W-1:0]      o_slot_index
);
    import htlp_pkg::*;

    localparam int F      = HASH_FRACTION_BITS;
    localparam int TSW    = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W  = (SLOT_W < 1) ? 1 : SLOT_W;
    localparam int USED_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [F-1:0]     HASH_MULT = F'(GOLDEN_FRAC64 >> (64 - F));
    localparam logic [TSW-1:0]   SLOTS_C   = TSW'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef struct packed {
        logic [63:0]        key;
        logic [3:0]         len;
        logic signed [31:0] value;
    } t_slot_rec;

    // Stores.
    logic [1:0] r_status_mem [TABLE_SLOTS];
    t_slot_rec  r_rec_mem    [TABLE_SLOTS];
    logic [1:0] r_rd_status;
    t_slot_rec  r_rd_rec;

    // Latched transaction.
    logic [1:0]         r_action;
    logic [63:0]        r_key;
    logic [3:0]         r_len;
    logic signed [31:0] r_value;

    // Hash and probe state.
    logic [3:0]        r_cnt;
    logic [F-1:0]      r_cfrac;
    logic [F-1:0]      r_h;
    logic [SLOT_W-1:0] r_pos;
    logic [SLOT_W-1:0] r_chk_pos;
    logic [CNT_W-1:0]  r_nchk;
    logic [SLOT_W-1:0] r_clr_addr;
    logic [USED_W-1:0] r_used;

    logic [3:0]     len_sat;
    logic [63:0]    key_masked;
    logic [2:0]     byte_idx;
    logic [7:0]     cur_byte;
    logic [F+7:0]   cprod;
    logic [F-1:0]   fold_sum;
    logic [F-1:0]   fold_next;
    logic [F+TSW-1:0] home_prod;
    logic [SLOT_W-1:0] pos_next;

    always_comb begin
        len_sat = (i_key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : i_key_length;
        for (int i = 0; i < 8; i++) begin
            key_masked[i*8 +: 8] = (4'(i) < len_sat) ? i_key_bytes[i*8 +: 8] : 8'h00;
        end
    end

    assign byte_idx  = 3'(r_cnt - 4'd1);
    assign cur_byte  = r_key[{byte_idx, 3'b000} +: 8];
    assign cprod     = (F+8)'(cur_byte) * (F+8)'(HASH_MULT);
    assign fold_sum  = r_h + r_cfrac;
    assign fold_next = F'(fold_sum << 5) + fold_sum;
    assign home_prod = (F+TSW)'(SLOTS_C) * (F+TSW)'(r_h);
    assign pos_next  = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;

    // Transaction latch and hash sequencing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= key_masked;
            r_len    <= len_sat;
            r_value  <= i_new_value;
            r_cnt    <= len_sat;
            r_h      <= '0;
        end
        if (i_cmd.hash_mul) begin
            r_cfrac <= cprod[F-1:0];
        end
        if (i_cmd.hash_fold) begin
            r_h   <= fold_next;
            r_cnt <= r_cnt - 4'd1;
        end
        if (i_cmd.home) begin
            r_pos <= SLOT_W'(home_prod >> F);
        end
        if (i_cmd.issue) begin
            r_chk_pos <= r_pos;
            r_pos     <= pos_next;
            r_nchk    <= '0;
        end
        if (i_cmd.advance) begin
            r_chk_pos <= r_pos;
            r_pos     <= pos_next;
            r_nchk    <= r_nchk + 1'b1;
        end
    end

    // Clear pointer and live count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_used     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.used_inc) begin
                r_used <= r_used + 1'b1;
            end else if (i_cmd.used_dec && (r_used != '0)) begin
                r_used <= r_used - 1'b1;
            end
        end
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_status_mem[r_clr_addr] <= SLOT_EMPTY;
        end else if (i_cmd.write_live) begin
            r_status_mem[r_chk_pos] <= SLOT_LIVE;
        end else if (i_cmd.write_tomb) begin
            r_status_mem[r_chk_pos] <= SLOT_TOMB;
        end
        if (i_cmd.write_live) begin
            r_rec_mem[r_chk_pos] <= '{key: r_key, len: r_len, value: r_value};
        end
        r_rd_status <= r_status_mem[r_pos];
        r_rd_rec    <= r_rec_mem[r_pos];
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.result_en) begin
            case (i_cmd.result_sel)
                RES_PUT_OK: begin
                    o_status      <= STAT_DONE;
                    o_found_value <= '0;
                    o_slot_index  <= r_chk_pos;
                end
                RES_FOUND: begin
                    o_status      <= STAT_DONE;
                    o_found_value <= r_rd_rec.value;
                    o_slot_index  <= r_chk_pos;
                end
                RES_FULL: begin
                    o_status      <= STAT_FULL;
                    o_found_value <= '0;
                    o_slot_index  <= '0;
                end
                default: begin
                    o_status      <= STAT_NOT_FOUND;
                    o_found_value <= '0;
                    o_slot_index  <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.action     = r_action;
        o_stat.len_zero   = (r_cnt == 4'd0);
        o_stat.cnt_last   = (r_cnt == 4'd1);
        o_stat.full       = (r_used >= USED_W'(TABLE_SLOTS));
        o_stat.clear_last = (r_clr_addr == LAST_SLOT);
        o_stat.slot_empty = (r_rd_status == SLOT_EMPTY);
        o_stat.slot_live  = (r_rd_status == SLOT_LIVE);
        o_stat.key_match  = (r_rd_rec.len == r_len) && (r_rd_rec.key == r_key);
        o_stat.last_probe = (r_nchk == CNT_W'(TABLE_SLOTS - 1));
    end

endmodule

@@ hw/rtl/htlp_ctrl.sv @@
// Controller: sequences clear pass, hashing, probing and result strobe.
`timescale 1ns / 1ps

module htlp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output logic                o_done,
    output htlp_pkg::t_dp_cmd   o_cmd,
    input  htlp_pkg::t_dp_stat  i_stat
);
    import htlp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_FOLD,
        S_HOME,
        S_ISSUE,
        S_PROBE
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.action) inside
                    ACT_PUT, ACT_GET, ACT_REMOVE: begin
                        if ((i_stat.action == ACT_PUT) && i_stat.full) begin
                            o_cmd.result_en  = 1'b1;
                            o_cmd.result_sel = RES_FULL;
                            n_done           = 1'b1;
                            n_state          = S_IDLE;
                        end else if (i_stat.len_zero) begin
                            n_state = S_HOME;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                    default: begin
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_NOT_FOUND;
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.hash_mul = 1'b1;
                n_state        = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.hash_fold = 1'b1;
                n_state         = i_stat.cnt_last ? S_HOME : S_MUL;
            end
            S_HOME: begin
                o_cmd.home = 1'b1;
                n_state    = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.action == ACT_PUT) begin
                    if (!i_stat.slot_live) begin
                        o_cmd.write_live = 1'b1;
                        o_cmd.used_inc   = 1'b1;
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_PUT_OK;
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end else if (i_stat.last_probe) begin
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_FULL;
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    if (i_stat.slot_empty) begin
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_NOT_FOUND;
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end else if (i_stat.slot_live && i_stat.key_match) begin
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_FOUND;
                        o_cmd.write_tomb = (i_stat.action == ACT_REMOVE);
                        o_cmd.used_dec   = (i_stat.action == ACT_REMOVE);
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end else if (i_stat.last_probe) begin
                        o_cmd.result_en  = 1'b1;
                        o_cmd.result_sel = RES_NOT_FOUND;
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

@@ hw/rtl/hash_table_linear_probe_core.sv @@
// Top level of the open-addressing hash table with linear probing and tombstones.
`timescale 1ns / 1ps

//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  command   | start, busy        | i_action, i_key_bytes, i_key_length, i_new_value
//  result    | o_done (1 cycle)   | o_status, o_found_value, o_slot_index
//
//  A command transaction is taken at a rising edge with start high and busy low.
//  Steps per transaction: dispatch, then a multiply and a fold per key byte, then form
//  the home slot and issue the first read, then probe up to TABLE_SLOTS slots, one slot
//  memory read per cycle; the result strobe is registered from the final decision
//  and shows while the core is already idle. An unknown action or a put into a full
//  table is answered at dispatch. After reset the core sweeps the slot state memory,
//  one slot per cycle, with busy high. The receiver cannot stall: o_done lasts one cycle.

module hash_table_linear_probe_core #(
    parameter int TABLE_SLOTS        = 64,
    parameter int KEY_CHARS          = 8,
    parameter int HASH_FRACTION_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_action,
    input  logic [63:0]                      i_key_bytes,
    input  logic [3:0]                       i_key_length,
    input  logic signed [31:0]               i_new_value,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic signed [31:0]               o_found_value,
    output logic [$clog2(TABLE_SLOTS)-1:0]   o_slot_index
);
    import htlp_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence the clear pass after reset, then each transaction: hash, probe, report.
    htlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Hold the key, run the hash, walk the slot memories and register the result.
    htlp_datapath #(
        .TABLE_SLOTS        (TABLE_SLOTS),
        .KEY_CHARS          (KEY_CHARS),
        .HASH_FRACTION_BITS (HASH_FRACTION_BITS),
        .SLOT_W             (SLOT_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_key_bytes   (i_key_bytes),
        .i_key_length  (i_key_length),
        .i_new_value   (i_new_value),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_slot_index  (o_slot_index)
    );

    // A result strobe only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // Failed transactions report zero value and slot.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_DONE)) |-> ((o_found_value == 0) && (o_slot_index == 0)))
        else $error("failed transaction reports nonzero value or slot");

    // An accepted command makes the core busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A live or tombstone slot write happens only while a probe decision is made.
    a_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.write_live || cmd.write_tomb) |-> (cmd.result_en && busy))
        else $error("slot write outside a probe decision");

endmodule
